### rtl/core/kvlt_pkg.sv
// Shared types and constants for the key/value list tokenizer
`default_nettype none

package kvlt_pkg;

   // parser phase, one-hot
   typedef enum logic [6:0] {
      PH_START    = 7'b000_0001,
      PH_KEY      = 7'b000_0010,
      PH_KEY_WS   = 7'b000_0100,
      PH_PRE_VAL  = 7'b000_1000,
      PH_BARE     = 7'b001_0000,
      PH_QUOTED   = 7'b010_0000,
      PH_POST_VAL = 7'b100_0000
   } phase_type;

   // byte role codes
   localparam logic [1:0] ROLE_DELIM = 2'd0;
   localparam logic [1:0] ROLE_KEY   = 2'd1;
   localparam logic [1:0] ROLE_VALUE = 2'd2;

   // error codes
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_KEY_START = 3'd1;
   localparam logic [2:0] ERR_NO_EQUALS = 3'd2;
   localparam logic [2:0] ERR_QUOTE     = 3'd3;
   localparam logic [2:0] ERR_TRAILING  = 3'd4;

   // special characters
   localparam logic [7:0] CH_END    = 8'h00;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_EQUALS = 8'h3D;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;

   // parser state carried from byte to byte
   typedef struct packed {
      phase_type phase;
      logic      quote_dbl;
      logic      after_comma;
   } state_type;

   localparam state_type STATE_RESET = '{phase: PH_START, quote_dbl: 1'b0, after_comma: 1'b0};

   // one result
   typedef struct packed {
      logic [1:0] byte_role;
      logic [7:0] data_byte;
      logic       pair_end;
      logic       finished;
      logic [2:0] error_code;
   } result_type;

endpackage

`default_nettype wire

### rtl/core/kvlt_step.sv
// Per-byte parser transition: next state and result for one request
`default_nettype none

module kvlt_step (
   input  kvlt_pkg::state_type  cur_state,
   input  logic [7:0]           char_code,
   output kvlt_pkg::state_type  next_state,
   output kvlt_pkg::result_type result
);

   function automatic logic is_ws(input logic [7:0] c);
      is_ws = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      is_alnum = ((c >= 8'h30) && (c <= 8'h39)) ||
                 ((c >= 8'h61) && (c <= 8'h7A)) ||
                 ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   logic                ws;
   logic                alnum;
   logic                close_hit;
   logic [1:0]          role;
   logic                pend;
   logic                fin;
   logic [2:0]          err;
   kvlt_pkg::state_type nxt;

   assign ws        = is_ws(char_code);
   assign alnum     = is_alnum(char_code);
   assign close_hit = cur_state.quote_dbl ? (char_code == kvlt_pkg::CH_DQUOTE)
                                          : (char_code == kvlt_pkg::CH_SQUOTE);

   // phase transition and tagging
   always_comb begin
      role = kvlt_pkg::ROLE_DELIM;
      pend = 1'b0;
      fin  = 1'b0;
      err  = kvlt_pkg::ERR_NONE;
      nxt  = cur_state;
      case (cur_state.phase)
         kvlt_pkg::PH_START: begin
            if (ws) begin
            end else if (char_code == kvlt_pkg::CH_END && !cur_state.after_comma) begin
               fin = 1'b1;
            end else if (alnum) begin
               role      = kvlt_pkg::ROLE_KEY;
               nxt.phase = kvlt_pkg::PH_KEY;
            end else begin
               err = kvlt_pkg::ERR_KEY_START;
            end
         end
         kvlt_pkg::PH_KEY: begin
            if (alnum || char_code == kvlt_pkg::CH_DASH || char_code == kvlt_pkg::CH_UNDER) begin
               role = kvlt_pkg::ROLE_KEY;
            end else if (ws) begin
               nxt.phase = kvlt_pkg::PH_KEY_WS;
            end else if (char_code == kvlt_pkg::CH_EQUALS) begin
               nxt.phase = kvlt_pkg::PH_PRE_VAL;
            end else begin
               err = kvlt_pkg::ERR_NO_EQUALS;
            end
         end
         kvlt_pkg::PH_KEY_WS: begin
            if (ws) begin
            end else if (char_code == kvlt_pkg::CH_EQUALS) begin
               nxt.phase = kvlt_pkg::PH_PRE_VAL;
            end else begin
               err = kvlt_pkg::ERR_NO_EQUALS;
            end
         end
         kvlt_pkg::PH_PRE_VAL: begin
            if (ws) begin
            end else if (char_code == kvlt_pkg::CH_DQUOTE || char_code == kvlt_pkg::CH_SQUOTE) begin
               nxt.quote_dbl = (char_code == kvlt_pkg::CH_DQUOTE);
               nxt.phase     = kvlt_pkg::PH_QUOTED;
            end else if (char_code == kvlt_pkg::CH_COMMA) begin
               pend            = 1'b1;
               nxt.after_comma = 1'b1;
               nxt.phase       = kvlt_pkg::PH_START;
            end else if (char_code == kvlt_pkg::CH_END) begin
               pend = 1'b1;
               fin  = 1'b1;
            end else begin
               role      = kvlt_pkg::ROLE_VALUE;
               nxt.phase = kvlt_pkg::PH_BARE;
            end
         end
         kvlt_pkg::PH_BARE: begin
            if (char_code == kvlt_pkg::CH_COMMA) begin
               pend            = 1'b1;
               nxt.after_comma = 1'b1;
               nxt.phase       = kvlt_pkg::PH_START;
            end else if (char_code == kvlt_pkg::CH_END) begin
               pend = 1'b1;
               fin  = 1'b1;
            end else if (ws) begin
               pend      = 1'b1;
               nxt.phase = kvlt_pkg::PH_POST_VAL;
            end else begin
               role = kvlt_pkg::ROLE_VALUE;
            end
         end
         kvlt_pkg::PH_QUOTED: begin
            if (close_hit) begin
               pend      = 1'b1;
               nxt.phase = kvlt_pkg::PH_POST_VAL;
            end else if (char_code == kvlt_pkg::CH_END) begin
               err = kvlt_pkg::ERR_QUOTE;
            end else begin
               role = kvlt_pkg::ROLE_VALUE;
            end
         end
         kvlt_pkg::PH_POST_VAL: begin
            if (ws) begin
            end else if (char_code == kvlt_pkg::CH_COMMA) begin
               nxt.after_comma = 1'b1;
               nxt.phase       = kvlt_pkg::PH_START;
            end else if (char_code == kvlt_pkg::CH_END) begin
               fin = 1'b1;
            end else begin
               err = kvlt_pkg::ERR_TRAILING;
            end
         end
         default: begin
            err = kvlt_pkg::ERR_KEY_START;
         end
      endcase
   end

   // a finished or failed string starts over
   always_comb begin
      if (fin || err != kvlt_pkg::ERR_NONE) begin
         next_state = kvlt_pkg::STATE_RESET;
      end else begin
         next_state = nxt;
      end
   end

   assign result = '{byte_role: role, data_byte: char_code, pair_end: pend,
                     finished: fin, error_code: err};

endmodule

`default_nettype wire

### rtl/core/key_value_list_tokenizer.sv
// Top level of the key/value list tokenizer: input register, parser state, result register
//
// Tokenizes a key=value list one byte per request, byte 0 ending the string, and returns
// exactly one result per byte: its role (key, value or delimiter), the byte itself, a
// pair-complete flag, a string-finished flag and an error code. A request is taken every
// clock while the result side is not stalled; the byte lands in the input register at
// the accepting edge, and the result register loads from it once the result side is not
// stalled. The phase update between those two registers is combinational: each byte's
// transition depends only on the state left by the byte before it. A stalled result
// holds the input register, which then stalls the request side. After a finish or an
// error the next byte begins a new string.
`default_nettype none

module key_value_list_tokenizer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_code,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_byte_role,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_pair_end,
   output logic       rsp_finished,
   output logic [2:0] rsp_error_code
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_char_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   kvlt_pkg::result_type rsp_ff;
   kvlt_pkg::state_type  state_ff, state_in;
   kvlt_pkg::result_type step_result;
   logic                 in_load;
   logic                 out_load;

   // handshake between the two register stages
   assign out_load  = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !out_load;
   assign in_load   = req_valid && !req_stall;

   always_comb begin
      if (in_load) begin
         in_valid_in = 1'b1;
      end else if (out_load) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   // parser transition
   kvlt_step u_step (
      .cur_state  (state_ff),
      .char_code  (in_char_ff),
      .next_state (state_in),
      .result     (step_result)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= kvlt_pkg::STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (out_load) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (in_load) begin
         in_char_ff <= req_char_code;
      end
      if (out_load) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_byte_role  = rsp_ff.byte_role;
   assign rsp_data_byte  = rsp_ff.data_byte;
   assign rsp_pair_end   = rsp_ff.pair_end;
   assign rsp_finished   = rsp_ff.finished;
   assign rsp_error_code = rsp_ff.error_code;

endmodule

`default_nettype wire

### rtl/core/kvlt_checker.sv
// Port-level checks for the key/value list tokenizer and their binding
`default_nettype none

module kvlt_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_char_code,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_byte_role,
   input logic [7:0] rsp_data_byte,
   input logic       rsp_pair_end,
   input logic       rsp_finished,
   input logic [2:0] rsp_error_code
);

   logic req_seen;
   assign req_seen = req_valid && !req_stall && (req_char_code == kvlt_pkg::CH_END);

   // no response right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // an error response carries no role and no finish
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error_code != kvlt_pkg::ERR_NONE) |->
         (rsp_byte_role == kvlt_pkg::ROLE_DELIM && !rsp_finished))
      else $error("error response tagged as key, value or finished");

   // finish only on the end byte
   a_finish_on_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_finished) |-> (rsp_data_byte == kvlt_pkg::CH_END))
      else $error("finish on a byte other than end of string");

   // a key or value byte is never the end byte, never completes a pair and carries no error
   a_token_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_byte_role != kvlt_pkg::ROLE_DELIM) |->
         (rsp_data_byte != kvlt_pkg::CH_END && !rsp_pair_end &&
          rsp_error_code == kvlt_pkg::ERR_NONE))
      else $error("token byte with end, pair end or error");

   // a stalled response stays valid with its byte, unless an end byte is being taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall && !req_seen) |=> (rsp_valid && $stable(rsp_data_byte)))
      else $error("stalled response changed");

endmodule

bind key_value_list_tokenizer kvlt_checker u_kvlt_checker (.*);

`default_nettype wire

### sim/kvlt_checker.sv
// Checker for the key/value list tokenizer: predicts every result and compares it
`timescale 1ns / 1ps

module kvlt_tb_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_char_code,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [1:0] rsp_byte_role,
   input  logic [7:0] rsp_data_byte,
   input  logic       rsp_pair_end,
   input  logic       rsp_finished,
   input  logic [2:0] rsp_error_code,
   output int         error_count,
   output int         open_count
);

   localparam int SHOWN_MAX = 10;

   kvlt_pkg::state_type  parse_state = kvlt_pkg::STATE_RESET;
   kvlt_pkg::result_type expected_tokens[$];
   int                   shown_count;

   function automatic logic is_space(input logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   // next parser step: classify one byte and advance the parse state
   function automatic kvlt_pkg::result_type tokenize_byte(input logic [7:0] c);
      kvlt_pkg::result_type r;
      r = '{byte_role: kvlt_pkg::ROLE_DELIM, data_byte: c, pair_end: 1'b0,
            finished: 1'b0, error_code: kvlt_pkg::ERR_NONE};
      case (parse_state.phase)
         kvlt_pkg::PH_START: begin
            if (is_space(c)) begin
            end else if (c == kvlt_pkg::CH_END && !parse_state.after_comma) begin
               r.finished = 1'b1;
            end else if (is_alnum(c)) begin
               r.byte_role = kvlt_pkg::ROLE_KEY;
               parse_state.phase = kvlt_pkg::PH_KEY;
            end else begin
               r.error_code = kvlt_pkg::ERR_KEY_START;
            end
         end
         kvlt_pkg::PH_KEY: begin
            if (is_alnum(c) || c == kvlt_pkg::CH_DASH || c == kvlt_pkg::CH_UNDER) begin
               r.byte_role = kvlt_pkg::ROLE_KEY;
            end else if (is_space(c)) begin
               parse_state.phase = kvlt_pkg::PH_KEY_WS;
            end else if (c == kvlt_pkg::CH_EQUALS) begin
               parse_state.phase = kvlt_pkg::PH_PRE_VAL;
            end else begin
               r.error_code = kvlt_pkg::ERR_NO_EQUALS;
            end
         end
         kvlt_pkg::PH_KEY_WS: begin
            if (is_space(c)) begin
            end else if (c == kvlt_pkg::CH_EQUALS) begin
               parse_state.phase = kvlt_pkg::PH_PRE_VAL;
            end else begin
               r.error_code = kvlt_pkg::ERR_NO_EQUALS;
            end
         end
         kvlt_pkg::PH_PRE_VAL: begin
            if (is_space(c)) begin
            end else if (c == kvlt_pkg::CH_DQUOTE || c == kvlt_pkg::CH_SQUOTE) begin
               parse_state.quote_dbl = (c == kvlt_pkg::CH_DQUOTE);
               parse_state.phase = kvlt_pkg::PH_QUOTED;
            end else if (c == kvlt_pkg::CH_COMMA) begin
               r.pair_end = 1'b1;
               parse_state.after_comma = 1'b1;
               parse_state.phase = kvlt_pkg::PH_START;
            end else if (c == kvlt_pkg::CH_END) begin
               r.pair_end = 1'b1;
               r.finished = 1'b1;
            end else begin
               r.byte_role = kvlt_pkg::ROLE_VALUE;
               parse_state.phase = kvlt_pkg::PH_BARE;
            end
         end
         kvlt_pkg::PH_BARE: begin
            if (c == kvlt_pkg::CH_COMMA) begin
               r.pair_end = 1'b1;
               parse_state.after_comma = 1'b1;
               parse_state.phase = kvlt_pkg::PH_START;
            end else if (c == kvlt_pkg::CH_END) begin
               r.pair_end = 1'b1;
               r.finished = 1'b1;
            end else if (is_space(c)) begin
               r.pair_end = 1'b1;
               parse_state.phase = kvlt_pkg::PH_POST_VAL;
            end else begin
               r.byte_role = kvlt_pkg::ROLE_VALUE;
            end
         end
         kvlt_pkg::PH_QUOTED: begin
            if (c == (parse_state.quote_dbl ? kvlt_pkg::CH_DQUOTE : kvlt_pkg::CH_SQUOTE)) begin
               r.pair_end = 1'b1;
               parse_state.phase = kvlt_pkg::PH_POST_VAL;
            end else if (c == kvlt_pkg::CH_END) begin
               r.error_code = kvlt_pkg::ERR_QUOTE;
            end else begin
               r.byte_role = kvlt_pkg::ROLE_VALUE;
            end
         end
         kvlt_pkg::PH_POST_VAL: begin
            if (is_space(c)) begin
            end else if (c == kvlt_pkg::CH_COMMA) begin
               parse_state.after_comma = 1'b1;
               parse_state.phase = kvlt_pkg::PH_START;
            end else if (c == kvlt_pkg::CH_END) begin
               r.finished = 1'b1;
            end else begin
               r.error_code = kvlt_pkg::ERR_TRAILING;
            end
         end
         default: begin
            r.error_code = kvlt_pkg::ERR_KEY_START;
         end
      endcase
      // a finish or an error starts a new string
      if (r.finished || r.error_code != kvlt_pkg::ERR_NONE)
         parse_state = kvlt_pkg::STATE_RESET;
      return r;
   endfunction

   // compare results first, then queue the prediction for a newly taken request
   always @(posedge clock) begin
      kvlt_pkg::result_type seen_token;
      kvlt_pkg::result_type want_token;
      if (reset) begin
         parse_state = kvlt_pkg::STATE_RESET;
         expected_tokens.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen_token = '{byte_role: rsp_byte_role, data_byte: rsp_data_byte,
                           pair_end: rsp_pair_end, finished: rsp_finished,
                           error_code: rsp_error_code};
            if (expected_tokens.size() == 0) begin
               error_count++;
               if (shown_count < SHOWN_MAX) begin
                  shown_count++;
                  $display("%0t: unexpected result role %0d byte %02h %s %0b %s %0b err %0d",
                           $realtime, seen_token.byte_role, seen_token.data_byte,
                           "pair_end", seen_token.pair_end, "fin", seen_token.finished,
                           seen_token.error_code);
               end
            end else begin
               want_token = expected_tokens.pop_front();
               if (seen_token.byte_role !== want_token.byte_role ||
                   seen_token.data_byte !== want_token.data_byte ||
                   seen_token.pair_end !== want_token.pair_end ||
                   seen_token.finished !== want_token.finished ||
                   seen_token.error_code !== want_token.error_code) begin
                  error_count++;
                  if (shown_count < SHOWN_MAX) begin
                     shown_count++;
                     $display("%0t: mismatch, expected role %0d byte %02h %s %0b %s %0b err %0d",
                              $realtime, want_token.byte_role, want_token.data_byte,
                              "pair_end", want_token.pair_end, "fin", want_token.finished,
                              want_token.error_code);
                     $display("%0t:           got role %0d byte %02h %s %0b %s %0b err %0d",
                              $realtime, seen_token.byte_role, seen_token.data_byte,
                              "pair_end", seen_token.pair_end, "fin", seen_token.finished,
                              seen_token.error_code);
                  end
               end
            end
         end
         if (req_valid && !req_stall)
            expected_tokens.push_back(tokenize_byte(req_char_code));
      end
      open_count = expected_tokens.size();
   end

endmodule

### sim/tb.sv
// Top of the tokenizer testbench: clock, reset, byte stimulus and the verdict
`timescale 1ns / 1ps

module tb;

   localparam int RANDOM_BYTES = 1800;

   // receiver stall behaviors
   localparam int STALL_NONE     = 0;
   localparam int STALL_LIGHT    = 1;
   localparam int STALL_HEAVY    = 2;
   localparam int STALL_PERIODIC = 3;

   localparam string ALNUM_CHARS =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789";
   localparam string SPACE_CHARS = "\011\012\013\014\015 ";

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_char_code = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_byte_role;
   logic [7:0] rsp_data_byte;
   logic       rsp_pair_end;
   logic       rsp_finished;
   logic [2:0] rsp_error_code;

   int error_count;
   int open_count;
   int sent_count = 0;
   int burst_left = 0;
   int no_gaps = 0;
   int stall_mode = STALL_NONE;
   int stall_left = 0;
   int random_base;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   key_value_list_tokenizer i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_char_code  (req_char_code),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_byte_role  (rsp_byte_role),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_pair_end   (rsp_pair_end),
      .rsp_finished   (rsp_finished),
      .rsp_error_code (rsp_error_code)
   );

   kvlt_tb_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_char_code  (req_char_code),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_byte_role  (rsp_byte_role),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_pair_end   (rsp_pair_end),
      .rsp_finished   (rsp_finished),
      .rsp_error_code (rsp_error_code),
      .error_count    (error_count),
      .open_count     (open_count)
   );

   // receiver stall, switching behavior at random intervals
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(STALL_NONE, STALL_PERIODIC);
         stall_left = $urandom_range(20, 120);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 2) != 0);
         default:     rsp_stall <= ((stall_left % 5) < 2);
      endcase
   end

   // one request, with a random gap at the start of each burst
   task automatic send_byte(input logic [7:0] c);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = no_gaps ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_char_code <= c;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      sent_count++;
   endtask

   task automatic send_text(input string s);
      foreach (s[i]) send_byte(s[i]);
   endtask

   // well-formed byte, now and then replaced by noise
   task automatic put_byte(input logic [7:0] c);
      if ($urandom_range(0, 49) == 0)
         c = 8'($urandom_range(0, 255));
      send_byte(c);
   endtask

   task automatic put_spaces();
      if ($urandom_range(0, 1) == 0)
         repeat ($urandom_range(1, 2)) put_byte(SPACE_CHARS[$urandom_range(0, 5)]);
   endtask

   task automatic put_key();
      put_byte(ALNUM_CHARS[$urandom_range(0, 61)]);
      repeat ($urandom_range(0, 5)) begin
         case ($urandom_range(0, 7))
            0:       put_byte(kvlt_pkg::CH_DASH);
            1:       put_byte(kvlt_pkg::CH_UNDER);
            default: put_byte(ALNUM_CHARS[$urandom_range(0, 61)]);
         endcase
      end
   endtask

   task automatic put_quoted(input logic [7:0] quote);
      logic [7:0] c;
      put_byte(quote);
      repeat ($urandom_range(0, 4)) begin
         do c = 8'($urandom_range(1, 255)); while (c == quote);
         put_byte(c);
      end
      put_byte(quote);
   endtask

   task automatic put_value();
      logic [7:0] c;
      case ($urandom_range(0, 3))
         0: begin
            // bare value: printable and high bytes, no comma
            repeat ($urandom_range(1, 5)) begin
               c = 8'($urandom_range(8'h21, 8'hFF));
               if (c == kvlt_pkg::CH_COMMA)
                  c = kvlt_pkg::CH_UNDER;
               put_byte(c);
            end
         end
         1: put_quoted(kvlt_pkg::CH_DQUOTE);
         2: put_quoted(kvlt_pkg::CH_SQUOTE);
         default: begin
            // empty value
         end
      endcase
   endtask

   // a whole list, mostly well formed, sometimes plain noise
   task automatic send_random_list();
      int pairs;
      no_gaps = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
      end else begin
         pairs = $urandom_range(0, 4);
         put_spaces();
         for (int p = 0; p < pairs; p++) begin
            put_key();
            put_spaces();
            put_byte(kvlt_pkg::CH_EQUALS);
            put_spaces();
            put_value();
            put_spaces();
            if (p < pairs - 1 || $urandom_range(0, 15) == 0) begin
               put_byte(kvlt_pkg::CH_COMMA);
               put_spaces();
            end
         end
         put_byte(kvlt_pkg::CH_END);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty string, then whitespace only
      send_byte(kvlt_pkg::CH_END);
      send_text(SPACE_CHARS);
      send_byte(kvlt_pkg::CH_END);
      // empty value closed by comma, then end right after the comma
      send_text("a=,");
      send_byte(kvlt_pkg::CH_END);
      // quoted value followed by trailing content
      send_text("Z_-9=\"'\" x");
      // key without equals, high byte as key start
      send_text("k'");
      send_byte(8'hFF);
      // unmatched quote, end inside a key
      send_text("b='");
      send_byte(kvlt_pkg::CH_END);
      send_text("q");
      send_byte(kvlt_pkg::CH_END);

      random_base = sent_count;
      while (sent_count - random_base < RANDOM_BYTES)
         send_random_list();
      req_valid <= 1'b0;

      while (open_count != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (error_count == 0 && open_count == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("tb: done, errors");
      $finish;
   end

endmodule

### sim.f
rtl/core/kvlt_pkg.sv
rtl/core/kvlt_step.sv
rtl/core/key_value_list_tokenizer.sv
rtl/core/kvlt_checker.sv
sim/kvlt_checker.sv
sim/tb.sv
